// ===== design/infix_to_postfix_converter_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the infix to postfix converter
// Shorthand for the concurrent checks in itp_ctrl.
// ----------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH

// Same-cycle implication, sampled on clk and ignored while rst is high.
`define ITP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("itp check failed");

// Next-cycle implication, sampled on clk and ignored while rst is high.
`define ITP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("itp check failed");

`endif

// ===== design/itp_pkg.sv =====
// ----------------------------------------------------------------------------
// itp_pkg
// Types, codes and helper functions shared by the converter modules.
// ----------------------------------------------------------------------------
package itp_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam logic [CNT_W-1:0] STACK_FULL = CNT_W'(STACK_DEPTH);

  typedef logic [2:0] code_t;

  localparam code_t CODE_NONE = 3'd0;
  localparam code_t CODE_ADD  = 3'd1;
  localparam code_t CODE_SUB  = 3'd2;
  localparam code_t CODE_MUL  = 3'd3;
  localparam code_t CODE_DIV  = 3'd4;
  localparam code_t CODE_PAR  = 3'd5;
  localparam code_t CODE_BRK  = 3'd6;
  localparam code_t CODE_BRC  = 3'd7;

  localparam logic [1:0] FAULT_NONE     = 2'd0;
  localparam logic [1:0] FAULT_MISMATCH = 2'd1;
  localparam logic [1:0] FAULT_OVERFLOW = 2'd2;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_LBRC  = 8'h7B;
  localparam logic [7:0] CH_RBRC  = 8'h7D;

  typedef struct packed {
    logic [7:0] sym;
    logic       end_expr;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_sym;
    logic       run_last;
    logic       expr_done;
    logic [1:0] status;
  } out_item_t;

  // Shift command broadcast to every stack cell.
  typedef struct packed {
    logic push;
    logic pop;
  } stack_op_t;

  function automatic logic [1:0] code_level(input code_t code);
    logic [1:0] lvl;
    begin
      if (code == CODE_MUL || code == CODE_DIV) begin
        lvl = 2'd3;
      end else if (code == CODE_ADD || code == CODE_SUB) begin
        lvl = 2'd2;
      end else begin
        lvl = 2'd1;
      end
      return lvl;
    end
  endfunction

  function automatic logic is_opener(input code_t code);
    return code >= CODE_PAR;
  endfunction

  function automatic logic [7:0] code_char(input code_t code);
    logic [7:0] ch;
    begin
      unique case (code)
        CODE_ADD: ch = CH_PLUS;
        CODE_SUB: ch = CH_MINUS;
        CODE_MUL: ch = CH_STAR;
        CODE_DIV: ch = CH_SLASH;
        CODE_PAR: ch = CH_LPAR;
        CODE_BRK: ch = CH_LBRK;
        CODE_BRC: ch = CH_LBRC;
        default:  ch = 8'h00;
      endcase
      return ch;
    end
  endfunction

endpackage

// ===== design/infix_to_postfix_converter.sv =====
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard converter: one infix character in, its postfix output out.
// ----------------------------------------------------------------------------
// Each transfer in is taken in the idle state and then handled in the
// processing state, which stays on for every operator popped from the
// operator stack; a flush also pops each leftover opener, while a closer
// removes the topmost opener in the step that returns to idle. The stack is a
// row of STACK_DEPTH shift cells that moves one entry per cycle unless a
// stalled output holds a pop, so popping sets the rate. Results wait in a
// one-entry output register and a stalled output holds up the sequencer only when it has a result to write.
module infix_to_postfix_converter
  import itp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  stack_op_t stack_op;
  code_t     push_code;
  code_t     cell_code [STACK_DEPTH];

  itp_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .top_code    (cell_code[0]),
    .second_code (cell_code[1]),
    .stack_op    (stack_op),
    .push_code   (push_code)
  );

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    code_t above;
    code_t below;
    if (i == 0) begin : g_top
      assign above = push_code;
    end else begin : g_mid
      assign above = cell_code[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bottom
      assign below = CODE_NONE;
    end else begin : g_inner
      assign below = cell_code[i+1];
    end
    itp_cell u_cell (
      .clk        (clk),
      .op         (stack_op),
      .from_above (above),
      .from_below (below),
      .code       (cell_code[i])
    );
  end

endmodule

// ===== design/itp_cell.sv =====
// ----------------------------------------------------------------------------
// itp_cell
// One entry of the shift stack: loads from the cell above on a push and
// from the cell below on a pop.
// ----------------------------------------------------------------------------
module itp_cell
  import itp_pkg::*;
(
  input  logic      clk,
  input  stack_op_t op,
  input  code_t     from_above,
  input  code_t     from_below,
  output code_t     code
);

  always_ff @(posedge clk) begin
    if (op.push) begin
      code <= from_above;
    end else if (op.pop) begin
      code <= from_below;
    end
  end

endmodule

// ===== design/itp_ctrl.sv =====
// ----------------------------------------------------------------------------
// itp_ctrl
// Sequencer for the converter: decodes each character, drives the cell row
// one push or pop per cycle unless a stalled output holds a pop, keeps the
// fill count and fault, and holds the output register.
// ----------------------------------------------------------------------------
`include "infix_to_postfix_converter_macros.svh"

module itp_ctrl
  import itp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item,
  input  code_t     top_code,
  input  code_t     second_code,
  output stack_op_t stack_op,
  output code_t     push_code
);

  typedef enum logic {
    S_IDLE,
    S_PROC
  } state_t;

  state_t           state;
  logic [7:0]       item_sym;
  logic             item_end;
  logic [CNT_W-1:0] cnt;
  logic [1:0]       fault;
  logic             ovalid;

  logic             finish, opener, closer, arith;
  code_t            want_code, new_code;
  logic [1:0]       new_level;
  logic             can_emit, stack_full, one_left;
  logic             emit, go_idle, clr_fault;
  logic [1:0]       set_fault;
  out_item_t        emit_item;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = ovalid;
  assign can_emit  = !ovalid || out_ready;
  assign stack_full = (cnt == STACK_FULL);
  assign one_left   = (cnt == CNT_W'(1));

  always_comb begin
    finish = item_end || item_sym == CH_HASH;
    opener = item_sym == CH_LPAR || item_sym == CH_LBRK || item_sym == CH_LBRC;
    closer = item_sym == CH_RPAR || item_sym == CH_RBRK || item_sym == CH_RBRC;
    arith  = item_sym == CH_PLUS || item_sym == CH_MINUS ||
             item_sym == CH_STAR || item_sym == CH_SLASH;
    unique case (item_sym)
      CH_RPAR: want_code = CODE_PAR;
      CH_RBRK: want_code = CODE_BRK;
      default: want_code = CODE_BRC;
    endcase
    unique case (item_sym)
      CH_LPAR:  new_code = CODE_PAR;
      CH_LBRK:  new_code = CODE_BRK;
      CH_LBRC:  new_code = CODE_BRC;
      CH_PLUS:  new_code = CODE_ADD;
      CH_MINUS: new_code = CODE_SUB;
      CH_STAR:  new_code = CODE_MUL;
      default:  new_code = CODE_DIV;
    endcase
    new_level = code_level(new_code);
  end

  always_comb begin
    stack_op  = '0;
    push_code = new_code;
    emit      = 1'b0;
    go_idle   = 1'b0;
    clr_fault = 1'b0;
    set_fault = FAULT_NONE;
    emit_item = '0;
    emit_item.out_sym = code_char(top_code);
    if (state == S_PROC) begin
      if (finish) begin
        if (cnt != '0) begin
          if (is_opener(top_code)) begin
            stack_op.pop = 1'b1;
            set_fault    = FAULT_MISMATCH;
          end else if (can_emit) begin
            stack_op.pop = 1'b1;
            emit         = 1'b1;
          end
        end else if (can_emit) begin
          emit                = 1'b1;
          emit_item.out_sym   = 8'h00;
          emit_item.run_last  = 1'b1;
          emit_item.expr_done = 1'b1;
          emit_item.status    = fault;
          clr_fault           = 1'b1;
          go_idle             = 1'b1;
        end
      end else if (opener) begin
        go_idle = 1'b1;
        if (stack_full) begin
          set_fault = FAULT_OVERFLOW;
        end else begin
          stack_op.push = 1'b1;
        end
      end else if (closer) begin
        if (cnt == '0) begin
          set_fault = FAULT_MISMATCH;
          go_idle   = 1'b1;
        end else if (is_opener(top_code)) begin
          stack_op.pop = 1'b1;
          go_idle      = 1'b1;
          if (top_code != want_code) begin
            set_fault = FAULT_MISMATCH;
          end
        end else if (can_emit) begin
          // Look one entry down to know whether this pop ends the run.
          stack_op.pop       = 1'b1;
          emit               = 1'b1;
          emit_item.run_last = one_left || is_opener(second_code);
        end
      end else if (arith) begin
        if (cnt != '0 && code_level(top_code) >= new_level) begin
          if (can_emit) begin
            stack_op.pop       = 1'b1;
            emit               = 1'b1;
            emit_item.run_last = one_left || (code_level(second_code) < new_level);
          end
        end else begin
          go_idle = 1'b1;
          if (stack_full) begin
            set_fault = FAULT_OVERFLOW;
          end else begin
            stack_op.push = 1'b1;
          end
        end
      end else if (can_emit) begin
        emit               = 1'b1;
        emit_item.out_sym  = item_sym;
        emit_item.run_last = 1'b1;
        go_idle            = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      fault  <= FAULT_NONE;
      ovalid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) state <= S_PROC;
        S_PROC: if (go_idle) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
      if (stack_op.push) begin
        cnt <= cnt + CNT_W'(1);
      end else if (stack_op.pop) begin
        cnt <= cnt - CNT_W'(1);
      end
      if (clr_fault) begin
        fault <= FAULT_NONE;
      end else if (set_fault != FAULT_NONE && fault == FAULT_NONE) begin
        fault <= set_fault;
      end
      if (emit) begin
        ovalid <= 1'b1;
      end else if (out_ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_sym <= in_item.sym;
      item_end <= in_item.end_expr;
    end
    if (emit) begin
      out_item <= emit_item;
    end
  end

  `ITP_ASSERT_SAME(a_cnt_bound, 1'b1, cnt <= STACK_FULL)
  `ITP_ASSERT_SAME(a_done_is_last, out_valid && out_item.expr_done, out_item.run_last)
  `ITP_ASSERT_SAME(a_status_on_term, out_valid && !out_item.expr_done,
                   out_item.status == FAULT_NONE)
  `ITP_ASSERT_NEXT(a_term_clears, emit && emit_item.expr_done,
                   cnt == '0 && fault == FAULT_NONE)
  `ITP_ASSERT_SAME(a_one_shift, 1'b1, !(stack_op.push && stack_op.pop))

endmodule
